@@ rtl/core/plce_pkg.sv @@
package plce_pkg;

  // default sizes of the block
  localparam int unsigned SUBFRAME_LEN_DEF = 20;
  localparam int unsigned STORE_DEPTH_DEF  = 512;
  localparam int unsigned QUEUE_DEPTH      = 2;

  // field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CORR_W    = 36;
  localparam int unsigned ENERGY_W  = 35;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;
  localparam int unsigned NSUB_W    = 4;
  localparam int unsigned LAG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBFRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG       = 1'd1;

  // register reset values
  localparam logic [NSUB_W-1:0] NUM_SUBFRAMES_RST = 4'd4;
  localparam logic [LAG_W-1:0]  MIN_LAG_RST       = 8'd10;

  // input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // kind of work handed from front to back
  typedef enum logic {
    OP_WRITE,
    OP_QUERY
  } op_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic                       command;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic [2:0]                 subframe;
    logic [LAG_W-1:0]           lag_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correlation;
    logic [ENERGY_W-1:0]      lag_energy;
    logic [ENERGY_W-1:0]      target_energy;
    logic                     status;
  } out_item_t;

endpackage

@@ rtl/core/plce_queue.sv @@
module plce_queue
  import plce_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/plce_front.sv @@
module plce_front
  import plce_pkg::*;
#(
  parameter int unsigned SUBFRAME_LEN = SUBFRAME_LEN_DEF,
  parameter int unsigned STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int unsigned AW           = $clog2(STORE_DEPTH),
  parameter int unsigned ENTRY_W      = 2 + 2 * AW + SAMPLE_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output logic                 push_o,
  output logic [ENTRY_W-1:0]   push_data_o,
  input  logic                 push_ready_i
);

  localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned SW = FW + 12;

  logic [FW-1:0]      fill_q, fill_d;
  logic [NSUB_W-1:0]  num_subframes_q;
  logic [LAG_W-1:0]   min_lag_q;
  logic               accept, is_query, store_ok;
  logic [AW-1:0]      wr_addr;
  logic signed [SW-1:0] fill_s, diff_s, lag_s, t_s, l_s, end_s;
  logic               range_err;
  op_e                kind;
  logic [AW-1:0]      addr_a, addr_b;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = push_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_query    = (in_item_i.command == CMD_QUERY);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_subframes_q <= NUM_SUBFRAMES_RST;
      min_lag_q       <= MIN_LAG_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NUM_SUBFRAMES: num_subframes_q <= cfg_data_i[NSUB_W-1:0];
        CFG_MIN_LAG:       min_lag_q       <= cfg_data_i[LAG_W-1:0];
        default:           ;
      endcase
    end
  end

  // load path: restart empties the store, a full store drops the sample
  always_comb begin
    fill_d   = fill_q;
    store_ok = 1'b0;
    wr_addr  = fill_q[AW-1:0];
    if (in_item_i.restart) begin
      wr_addr  = '0;
      store_ok = 1'b1;
      fill_d   = FW'(1);
    end else if (fill_q < FW'(STORE_DEPTH)) begin
      store_ok = 1'b1;
      fill_d   = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept && !is_query) begin
      fill_q <= fill_d;
    end
  end

  // query windows: target start, lagged start and range check
  always_comb begin
    fill_s = SW'(fill_q);
    diff_s = SW'(signed'({1'b0, num_subframes_q})) - SW'(signed'({1'b0, in_item_i.subframe}));
    t_s    = fill_s - SW'(SUBFRAME_LEN) * diff_s;
    lag_s  = SW'(min_lag_q) + SW'(in_item_i.lag_index);
    l_s    = t_s - lag_s;
    end_s  = t_s + SW'(SUBFRAME_LEN);
    range_err = l_s[SW-1] || (end_s > fill_s);
  end

  // hand the classified item to the back end
  always_comb begin
    if (is_query) begin
      kind   = OP_QUERY;
      addr_a = t_s[AW-1:0];
      addr_b = l_s[AW-1:0];
    end else begin
      kind   = OP_WRITE;
      addr_a = wr_addr;
      addr_b = '0;
    end
  end

  assign push_o      = accept && (is_query || store_ok);
  assign push_data_o = {kind, is_query && range_err, addr_a, addr_b, in_item_i.sample};

endmodule

@@ rtl/core/plce_back.sv @@
module plce_back
  import plce_pkg::*;
#(
  parameter int unsigned SUBFRAME_LEN = SUBFRAME_LEN_DEF,
  parameter int unsigned STORE_DEPTH  = STORE_DEPTH_DEF,
  parameter int unsigned AW           = $clog2(STORE_DEPTH),
  parameter int unsigned ENTRY_W      = 2 + 2 * AW + SAMPLE_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  logic [ENTRY_W-1:0] pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  localparam int unsigned KW  = $clog2(SUBFRAME_LEN + 1);
  localparam int unsigned PCW = 2 * SAMPLE_W;
  localparam int unsigned PEW = 2 * SAMPLE_W - 1;
  localparam int unsigned ACW = PCW + $clog2(SUBFRAME_LEN);
  localparam int unsigned AEW = PEW + $clog2(SUBFRAME_LEN);
  localparam logic signed [63:0] CORR_HI   = 64'sd34359738367;
  localparam logic signed [63:0] CORR_LO   = -64'sd34359738368;
  localparam logic        [63:0] ENERGY_HI = 64'd34359738367;

  // queue entry fields
  logic                q_kind, q_err;
  logic [AW-1:0]       q_addr_a, q_addr_b;
  logic [SAMPLE_W-1:0] q_data;
  assign {q_kind, q_err, q_addr_a, q_addr_b, q_data} = pop_data_i;

  back_state_e state_q, state_d;
  logic        mem_we, start, start_err, issue, load_res;

  logic [SAMPLE_W-1:0]        mem_q [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]              addr_a_q, addr_b_q;
  logic [KW-1:0]              cnt_q;
  logic                       rd_v_q, pr_v_q, err_q;
  logic signed [PCW-1:0]      prod_c_q;
  logic [PEW-1:0]             prod_l_q, prod_t_q;
  logic signed [PCW-1:0]      mul_c, mul_l, mul_t;
  logic signed [ACW-1:0]      corr_acc_q;
  logic [AEW-1:0]             lag_acc_q, tgt_acc_q;
  logic                       out_valid_q;
  out_item_t                  out_q, res;
  logic signed [63:0]         corr_ext;
  logic [63:0]                lag_ext, tgt_ext;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i && (q_kind == OP_QUERY)) begin
          state_d = q_err ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == KW'(SUBFRAME_LEN - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !pr_v_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    start     = 1'b0;
    start_err = 1'b0;
    issue     = 1'b0;
    load_res  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        pop_o = pop_valid_i;
        if (pop_valid_i) begin
          if (q_kind == OP_QUERY) begin
            start     = !q_err;
            start_err = q_err;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   load_res = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_v_q  <= 1'b0;
      pr_v_q  <= 1'b0;
      cnt_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      pr_v_q  <= rd_v_q;
      if (start || start_err) begin
        cnt_q <= '0;
        err_q <= start_err;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // sample store, one write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_addr_a] <= q_data;
    end
    if (issue) begin
      rd_a_q <= mem_q[addr_a_q];
      rd_b_q <= mem_q[addr_b_q];
    end
  end

  // window address walk
  always_ff @(posedge clk_i) begin
    if (start) begin
      addr_a_q <= q_addr_a;
      addr_b_q <= q_addr_b;
    end else if (issue) begin
      addr_a_q <= addr_a_q + 1'b1;
      addr_b_q <= addr_b_q + 1'b1;
    end
  end

  // products, registered before accumulation
  assign mul_c = PCW'(rd_a_q) * PCW'(rd_b_q);
  assign mul_l = PCW'(rd_b_q) * PCW'(rd_b_q);
  assign mul_t = PCW'(rd_a_q) * PCW'(rd_a_q);

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      prod_c_q <= mul_c;
      prod_l_q <= mul_l[PEW-1:0];
      prod_t_q <= mul_t[PEW-1:0];
    end
  end

  // accumulators
  always_ff @(posedge clk_i) begin
    if (start || start_err) begin
      corr_acc_q <= '0;
      lag_acc_q  <= '0;
      tgt_acc_q  <= '0;
    end else if (pr_v_q) begin
      corr_acc_q <= corr_acc_q + ACW'(prod_c_q);
      lag_acc_q  <= lag_acc_q + AEW'(prod_l_q);
      tgt_acc_q  <= tgt_acc_q + AEW'(prod_t_q);
    end
  end

  // saturation, energy floor and error result
  always_comb begin
    corr_ext = 64'(corr_acc_q);
    lag_ext  = 64'(lag_acc_q);
    tgt_ext  = 64'(tgt_acc_q);
    res      = '0;
    if (err_q) begin
      res.status = STATUS_RANGE;
    end else begin
      res.status = STATUS_OK;
      if (corr_ext > CORR_HI) begin
        res.correlation = CORR_HI[CORR_W-1:0];
      end else if (corr_ext < CORR_LO) begin
        res.correlation = CORR_LO[CORR_W-1:0];
      end else begin
        res.correlation = corr_ext[CORR_W-1:0];
      end
      if (lag_ext == '0) begin
        res.lag_energy = ENERGY_W'(1);
      end else if (lag_ext > ENERGY_HI) begin
        res.lag_energy = ENERGY_HI[ENERGY_W-1:0];
      end else begin
        res.lag_energy = lag_ext[ENERGY_W-1:0];
      end
      if (tgt_ext == '0) begin
        res.target_energy = ENERGY_W'(1);
      end else if (tgt_ext > ENERGY_HI) begin
        res.target_energy = ENERGY_HI[ENERGY_W-1:0];
      end else begin
        res.target_energy = tgt_ext[ENERGY_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  a_energy_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_OK) |->
      (out_item_o.lag_energy != '0) && (out_item_o.target_energy != '0))
    else $error("energy below floor on a good result");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STATUS_RANGE) |->
      (out_item_o.correlation == '0) && (out_item_o.lag_energy == '0) &&
      (out_item_o.target_energy == '0))
    else $error("range error result carries nonzero sums");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= KW'(SUBFRAME_LEN))
    else $error("window walk ran past the subframe");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside the finish step");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> !$past(pop_o))
    else $error("queue popped while a query was running");

endmodule

@@ rtl/core/pitch_lag_correlation_energy_core.sv @@
// Pitch-lag correlation engine. Load items append Q15 samples to an internal
// store of STORE_DEPTH entries (restart empties it first, a load into a full
// store is dropped); query items return the cross-correlation, lagged-window
// energy and target energy of one subframe, or status 1 with zero sums when the
// windows leave the loaded samples. The front end takes one item per cycle,
// while the queue has room, into a two-entry queue while the back end works;
// a load is written into the store as it is popped, and a query in range is
// run by walking both windows through the store's two read ports, one sample
// pair a cycle, into one multiply-accumulate path per sum. The store needs no
// clearing pass: items are taken right after reset. Configuration writes are
// taken at any time but are meant for an idle block.
module pitch_lag_correlation_energy_core
  import plce_pkg::*;
#(
  parameter int unsigned SUBFRAME_LEN = SUBFRAME_LEN_DEF,
  parameter int unsigned STORE_DEPTH  = STORE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW      = $clog2(STORE_DEPTH);
  localparam int unsigned ENTRY_W = 2 + 2 * AW + SAMPLE_W;

  logic               push, push_ready, pop, pop_valid;
  logic [ENTRY_W-1:0] push_data, pop_data;

  // front: config, fill tracking and window classification
  plce_front #(
    .SUBFRAME_LEN(SUBFRAME_LEN),
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .push_ready_i(push_ready)
  );

  // queue between front and back
  plce_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .push_ready_o(push_ready),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  // back: sample store and multiply-accumulate walk
  plce_back #(
    .SUBFRAME_LEN(SUBFRAME_LEN),
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule
